### hw/rtl/lut_color_grading_defines.svh
// Assertion macros shared by the grading pipeline.
`ifndef LUT_COLOR_GRADING_DEFINES_SVH
`define LUT_COLOR_GRADING_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif

`endif

### hw/rtl/lcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcg_pkg;

    localparam int GRID_SIZE       = 32;
    localparam int ENTRY_FRAC_BITS = 12;
    localparam int CELL_BITS       = 3;
    localparam int CELL_SIZE       = 1 << CELL_BITS;
    localparam int PIX_W           = 8;
    localparam int ENTRY_W         = 13;
    localparam int IDX_W           = $clog2(GRID_SIZE);
    localparam int ADDR_W          = 3 * IDX_W;
    localparam int TABLE_DEPTH     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int N_W             = ENTRY_W + CELL_BITS;
    localparam int SCALE_W         = N_W + PIX_W;
    localparam int OUT_SHIFT       = ENTRY_FRAC_BITS + CELL_BITS;
    localparam int SAT_W           = SCALE_W - OUT_SHIFT;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] END_STEP  = ADDR_W'(1 + GRID_SIZE + GRID_SIZE * GRID_SIZE);
    localparam logic [IDX_W-1:0]  IDX_TOP   = IDX_W'(GRID_SIZE - 1);
    localparam logic [IDX_W-1:0]  IDX_CLAMP = IDX_W'(GRID_SIZE - 2);

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_GRADE = 1'b1
    } command_t;

    typedef struct packed
    {
        logic [ENTRY_W-1:0] red;
        logic [ENTRY_W-1:0] green;
        logic [ENTRY_W-1:0] blue;
    } entry_t;

    typedef struct packed
    {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_port_t;

    typedef struct packed
    {
        logic              en;
        logic [ADDR_W-1:0] addr_start;
        logic [ADDR_W-1:0] addr_end;
    } rd_port_t;

    function automatic logic [IDX_W-1:0] grid_index(input logic [PIX_W-1:0] c);
        logic [IDX_W-1:0] i;
        i = c[PIX_W-1:CELL_BITS];
        if (i == IDX_TOP)
        begin
            i = IDX_CLAMP;
        end
        return i;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lcg_table.sv
`timescale 1ns / 1ps
`default_nettype none

module lcg_table
(
    input  wire logic            clk,
    input  wire lcg_pkg::wr_port_t wr,
    input  wire lcg_pkg::rd_port_t rd,
    output lcg_pkg::entry_t      start_entry,
    output lcg_pkg::entry_t      end_entry
);

    lcg_pkg::entry_t mem [lcg_pkg::TABLE_DEPTH];
    lcg_pkg::entry_t start_entry_reg;
    lcg_pkg::entry_t end_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            start_entry_reg <= mem[rd.addr_start];
            end_entry_reg   <= mem[rd.addr_end];
        end
    end

    assign start_entry = start_entry_reg;
    assign end_entry   = end_entry_reg;

endmodule

`default_nettype wire

### hw/rtl/lcg_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module lcg_lane
(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [lcg_pkg::ENTRY_W-1:0]   start_value,
    input  wire logic [lcg_pkg::ENTRY_W-1:0]   end_value,
    input  wire logic [lcg_pkg::CELL_BITS-1:0] frac,
    output logic      [lcg_pkg::PIX_W-1:0]     result
);

    logic [lcg_pkg::CELL_BITS:0]   weight_start;
    logic [lcg_pkg::N_W-1:0]       term_start;
    logic [lcg_pkg::N_W-1:0]       term_end;
    logic [lcg_pkg::N_W-1:0]       blend_next;
    logic [lcg_pkg::N_W-1:0]       blend_reg;
    logic [lcg_pkg::SCALE_W-1:0]   scaled;
    logic [lcg_pkg::SAT_W-1:0]     level;

    // s*(8-f) + f*e, exact in N_W bits for any 13-bit entries
    assign weight_start = (lcg_pkg::CELL_BITS+1)'(lcg_pkg::CELL_SIZE) - {1'b0, frac};
    assign term_start   = lcg_pkg::N_W'(start_value) * lcg_pkg::N_W'(weight_start);
    assign term_end     = lcg_pkg::N_W'(end_value) * lcg_pkg::N_W'(frac);
    assign blend_next   = term_start + term_end;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            blend_reg <= blend_next;
        end
    end

    // times 255 as shift and subtract, then drop the fraction bits
    assign scaled = {blend_reg, lcg_pkg::PIX_W'(0)}
                  - {lcg_pkg::PIX_W'(0), blend_reg};
    assign level  = scaled[lcg_pkg::SCALE_W-1:lcg_pkg::OUT_SHIFT];

    always_comb
    begin
        if (|level[lcg_pkg::SAT_W-1:lcg_pkg::PIX_W])
        begin
            result = {lcg_pkg::PIX_W{1'b1}};
        end
        else
        begin
            result = level[lcg_pkg::PIX_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lut_color_grading.sv
// 3D colour-table grader, 32x32x32 entries of three Q.12 channel values.
// Input channel (in_valid / in_ready): command selects a table load or a
// pixel to grade. A load writes entry table_address; a load to address zero
// marks the table not ready, a load to the last address marks it ready.
// Pixels sent while the table is not ready are consumed and give no result.
// Output channel (out_valid / out_ready): one graded pixel per graded input.
// Throughput: one item per clock while out_ready stays high. The table is a
// single memory with one write port and two read ports (start and end
// corner of the cell diagonal), so both corners of a pixel are read together.
// A pixel accepted on the input is read from the memory at the accepting
// edge, then its blend is registered in each channel lane, then it is scaled
// and saturated into the output register that drives out_*.
// When the receiver stalls with a result pending, the whole pipeline holds
// and in_ready drops until the result is taken.
// Reset clears the ready flag and the pipeline valid bits; the table keeps
// its contents undefined until loaded, and there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "lut_color_grading_defines.svh"

module lut_color_grading
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 command,
    input  wire logic [lcg_pkg::ADDR_W-1:0]           table_address,
    input  wire logic [lcg_pkg::ENTRY_W-1:0]          entry_red,
    input  wire logic [lcg_pkg::ENTRY_W-1:0]          entry_green,
    input  wire logic [lcg_pkg::ENTRY_W-1:0]          entry_blue,
    input  wire logic [lcg_pkg::PIX_W-1:0]            pixel_red,
    input  wire logic [lcg_pkg::PIX_W-1:0]            pixel_green,
    input  wire logic [lcg_pkg::PIX_W-1:0]            pixel_blue,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [lcg_pkg::PIX_W-1:0]            out_red,
    output logic      [lcg_pkg::PIX_W-1:0]            out_green,
    output logic      [lcg_pkg::PIX_W-1:0]            out_blue
);

    logic                               pipe_en;
    logic                               in_xfer;
    logic                               is_load;
    logic                               is_grade;
    logic                               table_ready_reg;
    logic                               table_ready_next;
    logic                               fetch_valid_reg;
    logic                               blend_valid_reg;
    logic                               out_valid_reg;
    logic [lcg_pkg::CELL_BITS-1:0]      frac_red_reg;
    logic [lcg_pkg::CELL_BITS-1:0]      frac_green_reg;
    logic [lcg_pkg::CELL_BITS-1:0]      frac_blue_reg;
    logic [lcg_pkg::ADDR_W-1:0]         start_addr;
    logic [lcg_pkg::PIX_W-1:0]          lane_red;
    logic [lcg_pkg::PIX_W-1:0]          lane_green;
    logic [lcg_pkg::PIX_W-1:0]          lane_blue;
    logic [lcg_pkg::PIX_W-1:0]          out_red_reg;
    logic [lcg_pkg::PIX_W-1:0]          out_green_reg;
    logic [lcg_pkg::PIX_W-1:0]          out_blue_reg;
    lcg_pkg::wr_port_t                  wr;
    lcg_pkg::rd_port_t                  rd;
    lcg_pkg::entry_t                    start_entry;
    lcg_pkg::entry_t                    end_entry;

    // advance the whole pipe unless a result waits on a stalled receiver
    assign pipe_en  = !out_valid_reg || out_ready;
    assign in_ready = pipe_en;
    assign in_xfer  = in_valid && in_ready;
    assign is_load  = in_xfer && (command == lcg_pkg::CMD_LOAD);
    assign is_grade = in_xfer && (command == lcg_pkg::CMD_GRADE) && table_ready_reg;

    assign start_addr = {lcg_pkg::grid_index(pixel_blue),
                         lcg_pkg::grid_index(pixel_green),
                         lcg_pkg::grid_index(pixel_red)};

    assign wr.en         = is_load;
    assign wr.addr       = table_address;
    assign wr.data.red   = entry_red;
    assign wr.data.green = entry_green;
    assign wr.data.blue  = entry_blue;

    assign rd.en         = pipe_en;
    assign rd.addr_start = start_addr;
    assign rd.addr_end   = start_addr + lcg_pkg::END_STEP;

    always_comb
    begin
        table_ready_next = table_ready_reg;
        if (is_load && (table_address == '0))
        begin
            table_ready_next = 1'b0;
        end
        if (is_load && (table_address == lcg_pkg::LAST_ADDR))
        begin
            table_ready_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_ready_reg <= 1'b0;
            fetch_valid_reg <= 1'b0;
            blend_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            table_ready_reg <= table_ready_next;
            if (pipe_en)
            begin
                fetch_valid_reg <= is_grade;
                blend_valid_reg <= fetch_valid_reg;
                out_valid_reg   <= blend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            frac_red_reg   <= pixel_red[lcg_pkg::CELL_BITS-1:0];
            frac_green_reg <= pixel_green[lcg_pkg::CELL_BITS-1:0];
            frac_blue_reg  <= pixel_blue[lcg_pkg::CELL_BITS-1:0];
            out_red_reg    <= lane_red;
            out_green_reg  <= lane_green;
            out_blue_reg   <= lane_blue;
        end
    end

    lcg_table u_table
    (
        .clk         (clk),
        .wr          (wr),
        .rd          (rd),
        .start_entry (start_entry),
        .end_entry   (end_entry)
    );

    lcg_lane u_lane_red
    (
        .clk         (clk),
        .en          (pipe_en),
        .start_value (start_entry.red),
        .end_value   (end_entry.red),
        .frac        (frac_red_reg),
        .result      (lane_red)
    );

    lcg_lane u_lane_green
    (
        .clk         (clk),
        .en          (pipe_en),
        .start_value (start_entry.green),
        .end_value   (end_entry.green),
        .frac        (frac_green_reg),
        .result      (lane_green)
    );

    lcg_lane u_lane_blue
    (
        .clk         (clk),
        .en          (pipe_en),
        .start_value (start_entry.blue),
        .end_value   (end_entry.blue),
        .frac        (frac_blue_reg),
        .result      (lane_blue)
    );

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

    `ASSERT_CLK(a_drop_unready, (in_xfer && !table_ready_reg) |=> !fetch_valid_reg)
    `ASSERT_CLK(a_grade_enters, (in_xfer && command && table_ready_reg) |=> fetch_valid_reg)
    `ASSERT_CLK(a_load_zero_clears, (is_load && (table_address == '0)) |=> !table_ready_reg)
    `ASSERT_CLK(a_stall_fetch, (out_valid_reg && !out_ready) |=> $stable(fetch_valid_reg))
    `ASSERT_CLK(a_stall_blend, (out_valid_reg && !out_ready) |=> $stable(blend_valid_reg))
    `ASSERT_NEVER(a_no_load_stalled, wr.en && !pipe_en)

endmodule

`default_nettype wire

### test/lut_color_grading_test.sv
`timescale 1ns / 1ps

module lut_color_grading_test;

    import lcg_pkg::*;

    typedef logic [2:0][PIX_W-1:0] pixel_t;    // index 0 red, 1 green, 2 blue

    localparam int PIX_MAX   = 255;
    localparam int ONE_LEVEL = 4096;
    localparam int TOP_LEVEL = (1 << ENTRY_W) - 1;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic [ADDR_W-1:0]   table_address;
    logic [ENTRY_W-1:0]  entry_red;
    logic [ENTRY_W-1:0]  entry_green;
    logic [ENTRY_W-1:0]  entry_blue;
    logic [PIX_W-1:0]    pixel_red;
    logic [PIX_W-1:0]    pixel_green;
    logic [PIX_W-1:0]    pixel_blue;
    logic                out_valid;
    logic                out_ready;
    logic [PIX_W-1:0]    out_red;
    logic [PIX_W-1:0]    out_green;
    logic [PIX_W-1:0]    out_blue;

    entry_t      lut_mirror [TABLE_DEPTH];
    bit          mirror_ready = 1'b0;
    pixel_t      pending_grades [$];
    int unsigned loaded_cells [$];
    string       chan_name [3] = '{"red", "green", "blue"};

    int error_count = 0;
    int items_sent  = 0;
    int hold_cycles = 0;
    int stall_left  = 0;
    bit idling_on   = 1'b0;
    bit stim_ready  = 1'b0;

    lut_color_grading u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .table_address (table_address),
        .entry_red     (entry_red),
        .entry_green   (entry_green),
        .entry_blue    (entry_blue),
        .pixel_red     (pixel_red),
        .pixel_green   (pixel_green),
        .pixel_blue    (pixel_blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_fault(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // Grade predictor and result check, both on accepted transfers.
    always @(posedge clk)
    begin : score
        pixel_t            px;
        pixel_t            got;
        pixel_t            want;
        entry_t            s_ent;
        entry_t            e_ent;
        logic [2:0][ENTRY_W-1:0] s_val;
        logic [2:0][ENTRY_W-1:0] e_val;
        logic [ADDR_W-1:0] start_addr;
        int unsigned       idx [3];
        int unsigned       frac;
        int unsigned       blend;
        int unsigned       scaled;
        int                k;

        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (command == CMD_LOAD)
                begin
                    lut_mirror[table_address] = '{red: entry_red, green: entry_green,
                                                  blue: entry_blue};
                    if (table_address == '0)
                    begin
                        mirror_ready = 1'b0;
                    end
                    if (table_address == LAST_ADDR)
                    begin
                        mirror_ready = 1'b1;
                    end
                end
                else if (mirror_ready)
                begin
                    px = {pixel_blue, pixel_green, pixel_red};
                    for (k = 0; k < 3; k++)
                    begin
                        idx[k] = 32'(px[k] >> CELL_BITS);
                        if (idx[k] == GRID_SIZE - 1)
                        begin
                            idx[k] = GRID_SIZE - 2;
                        end
                    end
                    start_addr = ADDR_W'(idx[0] + GRID_SIZE * idx[1]
                                         + GRID_SIZE * GRID_SIZE * idx[2]);
                    s_ent = lut_mirror[start_addr];
                    e_ent = lut_mirror[start_addr + END_STEP];
                    s_val = {s_ent.blue, s_ent.green, s_ent.red};
                    e_val = {e_ent.blue, e_ent.green, e_ent.red};
                    // Blend along the cell diagonal, then scale eighths of Q.12 to 8 bits.
                    for (k = 0; k < 3; k++)
                    begin
                        frac   = px[k] & (CELL_SIZE - 1);
                        blend  = s_val[k] * (CELL_SIZE - frac) + frac * e_val[k];
                        scaled = (blend * PIX_MAX) >> OUT_SHIFT;
                        want[k] = (scaled > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(scaled);
                    end
                    pending_grades.push_back(want);
                end
            end

            if (out_valid && out_ready)
            begin
                got = {out_blue, out_green, out_red};
                if (pending_grades.size() == 0)
                begin
                    report_fault($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                           got[0], got[1], got[2]));
                end
                else
                begin
                    want = pending_grades.pop_front();
                    for (k = 0; k < 3; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            report_fault($sformatf("%s mismatch: expected %0d, got %0d",
                                                   chan_name[k], want[k], got[k]));
                        end
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (idling_on && $urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(1, 19);
                end
            end
        end
    end

    function automatic logic [ENTRY_W-1:0] random_level();
        // Mostly 0.0 to 1.0, now and then above one to hit saturation.
        if ($urandom_range(0, 15) == 0)
        begin
            return ENTRY_W'($urandom_range(ONE_LEVEL + 1, TOP_LEVEL));
        end
        return ENTRY_W'($urandom_range(0, ONE_LEVEL));
    endfunction

    function automatic entry_t random_entry();
        entry_t e;
        e.red   = random_level();
        e.green = random_level();
        e.blue  = random_level();
        return e;
    endfunction

    task automatic send_item(input command_t cmd, input logic [ADDR_W-1:0] addr,
                             input entry_t ent, input pixel_t px);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        command       = cmd;
        table_address = addr;
        entry_red     = ent.red;
        entry_green   = ent.green;
        entry_blue    = ent.blue;
        pixel_red     = px[0];
        pixel_green   = px[1];
        pixel_blue    = px[2];
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (cmd == CMD_LOAD && addr == '0)
        begin
            stim_ready = 1'b0;
        end
        if (cmd == CMD_LOAD && addr == LAST_ADDR)
        begin
            stim_ready = 1'b1;
        end
    endtask

    task automatic load_entry(input logic [ADDR_W-1:0] addr, input entry_t ent);
        pixel_t junk;
        junk = (3 * PIX_W)'($urandom);
        send_item(CMD_LOAD, addr, ent, junk);
    endtask

    task automatic grade_pixel(input int r, input int g, input int b);
        logic [ADDR_W-1:0] junk;
        junk = ADDR_W'($urandom);
        send_item(CMD_GRADE, junk, random_entry(), {PIX_W'(b), PIX_W'(g), PIX_W'(r)});
    endtask

    // Load both diagonal corners of a cell so pixels in it read written entries.
    task automatic load_cell(input int r, input int g, input int b);
        logic [ADDR_W-1:0] start;
        start = ADDR_W'(r + GRID_SIZE * g + GRID_SIZE * GRID_SIZE * b);
        load_entry(start, random_entry());
        load_entry(start + END_STEP, random_entry());
        loaded_cells.push_back(32'(start));
    endtask

    task automatic grade_loaded_cell();
        int unsigned start;
        int          c [3];
        int          idx;
        int          k;
        start = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
        for (k = 0; k < 3; k++)
        begin
            idx = (start >> (k * IDX_W)) % GRID_SIZE;
            // The top index clamps onto the last cell, so it spans 16 codes.
            if (idx == GRID_SIZE - 2)
            begin
                c[k] = idx * CELL_SIZE + $urandom_range(0, 2 * CELL_SIZE - 1);
            end
            else
            begin
                c[k] = idx * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1);
            end
        end
        grade_pixel(c[0], c[1], c[2]);
    endtask

    task automatic test_grade_before_ready();
        grade_pixel(0, 0, 0);
        grade_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
    endtask

    task automatic test_diagonal_corners();
        load_entry('0, '{red: 0, green: ONE_LEVEL, blue: TOP_LEVEL});
        load_entry(END_STEP, '{red: ONE_LEVEL, green: 0, blue: TOP_LEVEL});
        load_entry(LAST_ADDR - END_STEP, '{red: TOP_LEVEL, green: ONE_LEVEL, blue: 0});
        load_entry(LAST_ADDR, '{red: 0, green: TOP_LEVEL, blue: ONE_LEVEL});
        loaded_cells.push_back(0);
        loaded_cells.push_back(32'(LAST_ADDR - END_STEP));
        grade_pixel(0, 0, 0);
        grade_pixel(7, 7, 7);
        grade_pixel(3, 5, 6);
        grade_pixel(240, 247, PIX_MAX);
        grade_pixel(248, PIX_MAX, 251);
    endtask

    task automatic test_ready_flag();
        load_entry('0, random_entry());
        grade_pixel(1, 2, 3);
        load_entry(LAST_ADDR, random_entry());
        grade_pixel(4, 4, 4);
    endtask

    task automatic test_random_sequences(input int target);
        int pick;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // Drop readiness, then offer pixels that must vanish.
                load_entry('0, random_entry());
                repeat ($urandom_range(1, 4)) grade_loaded_cell();
            end
            else if (pick == 1)
            begin
                load_entry(ADDR_W'($urandom_range(1, TABLE_DEPTH - 2)), random_entry());
            end
            else
            begin
                repeat ($urandom_range(0, 2))
                begin
                    load_cell($urandom_range(0, GRID_SIZE - 2),
                              $urandom_range(0, GRID_SIZE - 2),
                              $urandom_range(0, GRID_SIZE - 2));
                end
                if (!stim_ready)
                begin
                    load_entry(LAST_ADDR, random_entry());
                end
                repeat ($urandom_range(3, 10)) grade_loaded_cell();
            end
        end
    endtask

    task automatic test_output_hold_off();
        idling_on = 1'b0;
        if (!stim_ready)
        begin
            load_entry(LAST_ADDR, random_entry());
        end
        hold_cycles = 200;
        repeat (40) grade_loaded_cell();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_LOAD;
        table_address = '0;
        entry_red     = '0;
        entry_green   = '0;
        entry_blue    = '0;
        pixel_red     = '0;
        pixel_green   = '0;
        pixel_blue    = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_grade_before_ready();
        test_diagonal_corners();
        test_ready_flag();
        idling_on = 1'b1;
        test_random_sequences(250);
        test_output_hold_off();
        idling_on = 1'b1;
        test_random_sequences(450);
        idling_on = 1'b0;
        test_random_sequences(560);

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_grades.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
